@@ src/assert_macros.svh @@
// assertion macros used by the rtl top file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define AST_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");
`define AST_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define AST_IMP(lbl, clk, rstn, ante, cons)
`define AST_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

@@ src/urbx_pkg.sv @@
// package with types and constants of the uart ring buffers with xon/xoff
`default_nettype none
package urbx_pkg;

    localparam int RING_DEPTH_DEF = 1024;
    localparam int MARK_W         = 11;
    localparam int CFG_W          = 11;

    localparam logic [7:0] XON_CODE     = 8'h11;
    localparam logic [7:0] XOFF_CODE    = 8'h13;
    localparam logic [7:0] OVERFLOW_BIT = 8'h20;

    localparam logic [MARK_W-1:0] HIGH_MARK_RST = 11'd824;
    localparam logic [MARK_W-1:0] LOW_MARK_RST  = 11'd200;

    typedef enum logic [2:0] {
        REQ_LINE_RX  = 3'd0,
        REQ_TX_READY = 3'd1,
        REQ_HOST_PUT = 3'd2,
        REQ_HOST_GET = 3'd3,
        REQ_LINE_ERR = 3'd4,
        REQ_READ_ERR = 3'd5
    } t_req;

    typedef enum logic [2:0] {
        CFG_FLOW_EN   = 3'd0,
        CFG_TERM_EN   = 3'd1,
        CFG_TERM_CHAR = 3'd2,
        CFG_HIGH_MARK = 3'd3,
        CFG_LOW_MARK  = 3'd4
    } t_cfg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FIRST,
        ST_SECOND
    } t_state;

endpackage
`default_nettype wire

@@ src/uart_ring_buffers_xon_xoff_top.sv @@
// uart receive and transmit byte rings with xon/xoff flow control
//
//   channel   ports                                   handshake
//   request   i_req_type, i_data_byte                 start high, busy low
//   result    o_line_tx_* o_host_* o_error_bits ...   o_strobe, one cycle
//   config    i_cfg_we, i_cfg_idx, i_cfg_data         i_cfg_we, no wait
//
// a result shows in the cycle after its request, from the ring read register
// one request per cycle while busy is low; a tx ready that pops and also
// sends xon directly holds busy during its first result, and the second
// shows the next cycle; no clearing pass after reset: ring contents stay
// undefined until written; the receiver cannot stall, so results never wait
`default_nettype none
`include "assert_macros.svh"
module uart_ring_buffers_xon_xoff_top #(
    parameter int RING_DEPTH = urbx_pkg::RING_DEPTH_DEF,
    localparam int LVL_W = $clog2(RING_DEPTH + 1)
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     start,
    output logic                          busy,
    input  wire logic [2:0]               i_req_type,
    input  wire logic [7:0]               i_data_byte,
    input  wire logic                     i_cfg_we,
    input  wire logic [2:0]               i_cfg_idx,
    input  wire logic [urbx_pkg::CFG_W-1:0] i_cfg_data,
    output logic                          o_strobe,
    output logic                          o_line_tx_valid,
    output logic [7:0]                    o_line_tx_byte,
    output logic                          o_host_valid,
    output logic [7:0]                    o_host_byte,
    output logic [7:0]                    o_error_bits,
    output logic [15:0]                   o_msg_count,
    output logic [LVL_W-1:0]              o_rx_level,
    output logic [LVL_W-1:0]              o_tx_level,
    output logic                          o_last
);

    localparam int PTR_W = $clog2(RING_DEPTH);
    localparam int CMP_W = (LVL_W > urbx_pkg::MARK_W) ? LVL_W : urbx_pkg::MARK_W;
    localparam logic [LVL_W-1:0] DEPTH_L  = LVL_W'(RING_DEPTH);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(RING_DEPTH - 1);

    function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
        next_ptr = (p == PTR_LAST) ? '0 : p + 1'b1;
    endfunction

    urbx_pkg::t_state r_state, n_state;

    logic [7:0] rx_mem [RING_DEPTH];
    logic [7:0] tx_mem [RING_DEPTH];

    logic [PTR_W-1:0] r_rx_wr, r_rx_rd, r_tx_wr, r_tx_rd;
    logic [PTR_W-1:0] n_rx_wr, n_rx_rd, n_tx_wr, n_tx_rd;
    logic [LVL_W-1:0] r_rx_fill, r_tx_fill, n_rx_fill, n_tx_fill;
    logic             r_paused, r_throttled, n_paused, n_throttled;
    logic [15:0]      r_msg, n_msg;
    logic [7:0]       r_err, n_err;

    logic                       r_flow, r_term_en;
    logic [7:0]                 r_term_char;
    logic [urbx_pkg::MARK_W-1:0] r_high, r_low;

    logic       r_l1_v, r_l1_mem, r_two, r_host_v;
    logic       n_l1_v, n_l1_mem, n_two, n_host_v;
    logic [7:0] r_l1_byte, n_l1_byte, r_eb, n_eb;
    logic [7:0] r_rx_q, r_tx_q;

    logic       accept;
    logic       rx_we, tx_we, put_req, err_rd;
    logic [7:0] put_byte;
    logic       xon_out;

    assign accept = start && !busy;

    // request decode and state update
    always_comb begin
        n_rx_wr     = r_rx_wr;
        n_rx_rd     = r_rx_rd;
        n_rx_fill   = r_rx_fill;
        n_tx_wr     = r_tx_wr;
        n_tx_rd     = r_tx_rd;
        n_tx_fill   = r_tx_fill;
        n_paused    = r_paused;
        n_throttled = r_throttled;
        n_msg       = r_msg;
        n_err       = r_err;
        rx_we       = 1'b0;
        tx_we       = 1'b0;
        put_req     = 1'b0;
        put_byte    = urbx_pkg::XOFF_CODE;
        err_rd      = 1'b0;
        n_l1_v      = 1'b0;
        n_l1_mem    = 1'b0;
        n_l1_byte   = 8'h00;
        n_two       = 1'b0;
        n_host_v    = 1'b0;
        if (accept) begin
            case (urbx_pkg::t_req'(i_req_type))
                urbx_pkg::REQ_LINE_RX: begin
                    if (r_term_en && i_data_byte == r_term_char) begin
                        n_msg = r_msg + 16'd1;
                    end else if (r_flow) begin
                        if (i_data_byte == urbx_pkg::XON_CODE) begin
                            n_paused = 1'b0;
                        end else if (i_data_byte == urbx_pkg::XOFF_CODE) begin
                            n_paused = 1'b1;
                        end
                    end
                    if (r_rx_fill != DEPTH_L) begin
                        rx_we     = 1'b1;
                        n_rx_wr   = next_ptr(r_rx_wr);
                        n_rx_fill = r_rx_fill + 1'b1;
                    end
                    if (r_flow && !r_throttled && CMP_W'(n_rx_fill) > CMP_W'(r_high)) begin
                        put_req     = 1'b1;
                        put_byte    = urbx_pkg::XOFF_CODE;
                        n_throttled = 1'b1;
                    end
                end
                urbx_pkg::REQ_TX_READY: begin
                    if (!r_paused && r_tx_fill != '0) begin
                        n_l1_v    = 1'b1;
                        n_l1_mem  = 1'b1;
                        n_tx_rd   = next_ptr(r_tx_rd);
                        n_tx_fill = r_tx_fill - 1'b1;
                    end
                    if (r_flow && r_throttled && CMP_W'(r_rx_fill) < CMP_W'(r_low)) begin
                        put_req     = 1'b1;
                        put_byte    = urbx_pkg::XON_CODE;
                        n_throttled = 1'b0;
                    end
                end
                urbx_pkg::REQ_HOST_PUT: begin
                    put_req  = 1'b1;
                    put_byte = i_data_byte;
                end
                urbx_pkg::REQ_HOST_GET: begin
                    if (r_rx_fill != '0) begin
                        n_host_v  = 1'b1;
                        n_rx_rd   = next_ptr(r_rx_rd);
                        n_rx_fill = r_rx_fill - 1'b1;
                    end
                end
                urbx_pkg::REQ_LINE_ERR: begin
                    n_err = r_err | i_data_byte;
                end
                urbx_pkg::REQ_READ_ERR: begin
                    err_rd = 1'b1;
                    n_err  = 8'h00;
                end
                default: begin
                end
            endcase
            // empty ring: to line, full: dropped with overflow, else queued
            if (put_req) begin
                if (n_tx_fill == '0) begin
                    if (n_l1_v) begin
                        n_two = 1'b1;
                    end else begin
                        n_l1_v    = 1'b1;
                        n_l1_byte = put_byte;
                    end
                end else if (n_tx_fill == DEPTH_L) begin
                    n_err = n_err | urbx_pkg::OVERFLOW_BIT;
                end else begin
                    tx_we     = 1'b1;
                    n_tx_wr   = next_ptr(r_tx_wr);
                    n_tx_fill = n_tx_fill + 1'b1;
                end
            end
        end
        n_eb = err_rd ? r_err : n_err;
    end

    always_ff @(posedge i_clk) begin
        if (rx_we) begin
            rx_mem[r_rx_wr] <= i_data_byte;
        end
        if (accept) begin
            r_rx_q <= rx_mem[r_rx_rd];
        end
    end

    always_ff @(posedge i_clk) begin
        if (tx_we) begin
            tx_mem[r_tx_wr] <= put_byte;
        end
        if (accept) begin
            r_tx_q <= tx_mem[r_tx_rd];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= urbx_pkg::ST_IDLE;
            r_rx_wr     <= '0;
            r_rx_rd     <= '0;
            r_rx_fill   <= '0;
            r_tx_wr     <= '0;
            r_tx_rd     <= '0;
            r_tx_fill   <= '0;
            r_paused    <= 1'b0;
            r_throttled <= 1'b0;
            r_msg       <= '0;
            r_err       <= '0;
            r_l1_v      <= 1'b0;
            r_l1_mem    <= 1'b0;
            r_two       <= 1'b0;
            r_host_v    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rx_wr     <= n_rx_wr;
            r_rx_rd     <= n_rx_rd;
            r_rx_fill   <= n_rx_fill;
            r_tx_wr     <= n_tx_wr;
            r_tx_rd     <= n_tx_rd;
            r_tx_fill   <= n_tx_fill;
            r_paused    <= n_paused;
            r_throttled <= n_throttled;
            r_msg       <= n_msg;
            r_err       <= n_err;
            if (accept) begin
                r_l1_v   <= n_l1_v;
                r_l1_mem <= n_l1_mem;
                r_two    <= n_two;
                r_host_v <= n_host_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_l1_byte <= n_l1_byte;
            r_eb      <= n_eb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flow      <= 1'b0;
            r_term_en   <= 1'b0;
            r_term_char <= 8'h00;
            r_high      <= urbx_pkg::HIGH_MARK_RST;
            r_low       <= urbx_pkg::LOW_MARK_RST;
        end else if (i_cfg_we) begin
            case (urbx_pkg::t_cfg'(i_cfg_idx))
                urbx_pkg::CFG_FLOW_EN:   r_flow      <= i_cfg_data[0];
                urbx_pkg::CFG_TERM_EN:   r_term_en   <= i_cfg_data[0];
                urbx_pkg::CFG_TERM_CHAR: r_term_char <= i_cfg_data[7:0];
                urbx_pkg::CFG_HIGH_MARK: r_high      <= i_cfg_data[urbx_pkg::MARK_W-1:0];
                urbx_pkg::CFG_LOW_MARK:  r_low       <= i_cfg_data[urbx_pkg::MARK_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            urbx_pkg::ST_IDLE: begin
                if (accept) n_state = urbx_pkg::ST_FIRST;
            end
            urbx_pkg::ST_FIRST: begin
                if (r_two) begin
                    n_state = urbx_pkg::ST_SECOND;
                end else if (accept) begin
                    n_state = urbx_pkg::ST_FIRST;
                end else begin
                    n_state = urbx_pkg::ST_IDLE;
                end
            end
            urbx_pkg::ST_SECOND: begin
                n_state = accept ? urbx_pkg::ST_FIRST : urbx_pkg::ST_IDLE;
            end
            default: n_state = urbx_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        busy            = 1'b0;
        o_strobe        = 1'b0;
        o_line_tx_valid = 1'b0;
        o_line_tx_byte  = 8'h00;
        o_host_valid    = 1'b0;
        o_host_byte     = 8'h00;
        o_last          = 1'b0;
        case (r_state)
            urbx_pkg::ST_FIRST: begin
                busy            = r_two;
                o_strobe        = 1'b1;
                o_line_tx_valid = r_l1_v;
                o_line_tx_byte  = r_l1_mem ? r_tx_q : r_l1_byte;
                o_host_valid    = r_host_v;
                o_host_byte     = r_host_v ? r_rx_q : 8'h00;
                o_last          = !r_two;
            end
            urbx_pkg::ST_SECOND: begin
                o_strobe        = 1'b1;
                o_line_tx_valid = 1'b1;
                o_line_tx_byte  = urbx_pkg::XON_CODE;
                o_last          = 1'b1;
            end
            default: begin
            end
        endcase
    end

    assign o_error_bits = r_eb;
    assign o_msg_count  = r_msg;
    assign o_rx_level   = r_rx_fill;
    assign o_tx_level   = r_tx_fill;

    assign xon_out = o_line_tx_valid && o_line_tx_byte == urbx_pkg::XON_CODE;

    `AST_NXT(a_accept_result, i_clk, i_rst_n, accept, o_strobe)
    `AST_NXT(a_second_xon, i_clk, i_rst_n, o_strobe && !o_last, o_strobe && o_last && xon_out)
    `AST_IMP(a_rx_fill_max, i_clk, i_rst_n, 1'b1, r_rx_fill <= DEPTH_L && r_tx_fill <= DEPTH_L)
    `AST_IMP(a_tx_empty_ptrs, i_clk, i_rst_n, r_tx_fill == '0, r_tx_wr == r_tx_rd)

endmodule
`default_nettype wire
